[design/point_segment_closest_distance_top_defines.svh]
// Assertion macros for the closest-point pipeline.
// Used by point_segment_closest_distance_top; no other dependencies.
`ifndef POINT_SEGMENT_CLOSEST_DISTANCE_TOP_DEFINES_SVH
`define POINT_SEGMENT_CLOSEST_DISTANCE_TOP_DEFINES_SVH
// implication check under the block's clock and reset
`define PSCD_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// next-cycle check
`define PSCD_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

[design/pscd_pkg.sv]
// Shared types and constants of the closest-point-on-segment block.
// No dependencies.
package pscd_pkg;
    localparam int unsigned COORD_W = 24;
    localparam int unsigned GAP_W   = 26;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [GAP_W-1:0] gap_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t start_z;
        coord_t end_x;
        coord_t end_y;
        coord_t end_z;
        coord_t probe_x;
        coord_t probe_y;
        coord_t probe_z;
    } query_t;

    typedef struct packed {
        coord_t near_x;
        coord_t near_y;
        coord_t near_z;
        gap_t   gap;
        logic   degenerate;
    } answer_t;
endpackage

[design/pscd_if.sv]
// Valid/ready channel interface for one payload type.
// No dependencies; the payload type is a parameter.
interface pscd_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/point_segment_closest_distance_top.sv]
// Closest point on a 3D segment and distance to a query point.
// Throughput one transfer per cycle while the output is not stalled.
// Pipeline: dot products, a one-bit-per-stage divider, scaling, squares, a
// one-bit-per-stage square root; the whole pipe advances when the output slot frees.
// Reset clears only valid bits; payload registers hold anything.
`include "point_segment_closest_distance_top_defines.svh"
module point_segment_closest_distance_top #(
    parameter int unsigned T_FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    pscd_if.sink   in_ch,
    pscd_if.source out_ch
);
    import pscd_pkg::*;

    localparam int unsigned CW  = COORD_W;
    localparam int unsigned DW  = CW + 1;
    localparam int unsigned PW  = 2 * DW;
    localparam int unsigned SW  = PW + 2;
    localparam int unsigned TW  = T_FRAC_BITS + 1;
    localparam int unsigned QW  = 2 * DW + 2;
    localparam int unsigned RN  = 32;
    localparam int unsigned NST = 4 + T_FRAC_BITS + 4 + RN + 1;

    typedef enum logic [1:0] {MODE_DIV, MODE_ZERO, MODE_ONE} tmode_t;

    logic advance;
    logic [NST-1:0] vld_reg;
    assign advance = !vld_reg[NST-1] || out_ch.ready;
    assign in_ch.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_ch.valid};
        end
    end

    // stage 0: differences
    logic signed [DW-1:0] a0_reg [3];
    logic signed [DW-1:0] d0_reg [3];
    logic signed [DW-1:0] e0_reg [3];
    logic signed [DW-1:0] p0_reg [3];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a0_reg[0] <= DW'(in_ch.data.start_x);
            a0_reg[1] <= DW'(in_ch.data.start_y);
            a0_reg[2] <= DW'(in_ch.data.start_z);
            p0_reg[0] <= DW'(in_ch.data.probe_x);
            p0_reg[1] <= DW'(in_ch.data.probe_y);
            p0_reg[2] <= DW'(in_ch.data.probe_z);
            d0_reg[0] <= DW'(in_ch.data.end_x) - DW'(in_ch.data.start_x);
            d0_reg[1] <= DW'(in_ch.data.end_y) - DW'(in_ch.data.start_y);
            d0_reg[2] <= DW'(in_ch.data.end_z) - DW'(in_ch.data.start_z);
            e0_reg[0] <= DW'(in_ch.data.probe_x) - DW'(in_ch.data.start_x);
            e0_reg[1] <= DW'(in_ch.data.probe_y) - DW'(in_ch.data.start_y);
            e0_reg[2] <= DW'(in_ch.data.probe_z) - DW'(in_ch.data.start_z);
        end
    end

    // stage 1: products
    logic signed [PW-1:0] ed1_reg [3];
    logic signed [PW-1:0] dd1_reg [3];
    logic signed [DW-1:0] a1_reg [3];
    logic signed [DW-1:0] d1_reg [3];
    logic signed [DW-1:0] p1_reg [3];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ed1_reg[k] <= e0_reg[k] * d0_reg[k];
                dd1_reg[k] <= d0_reg[k] * d0_reg[k];
                a1_reg[k]  <= a0_reg[k];
                d1_reg[k]  <= d0_reg[k];
                p1_reg[k]  <= p0_reg[k];
            end
        end
    end

    // stage 2: sums
    logic signed [SW-1:0] num2_reg, den2_reg;
    logic signed [DW-1:0] a2_reg [3];
    logic signed [DW-1:0] d2_reg [3];
    logic signed [DW-1:0] p2_reg [3];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num2_reg <= SW'(ed1_reg[0]) + SW'(ed1_reg[1]) + SW'(ed1_reg[2]);
            den2_reg <= SW'(dd1_reg[0]) + SW'(dd1_reg[1]) + SW'(dd1_reg[2]);
            a2_reg <= a1_reg;
            d2_reg <= d1_reg;
            p2_reg <= p1_reg;
        end
    end

    // stage 3: classify
    logic [SW-1:0] rem3_reg, den3_reg;
    tmode_t mode3_reg;
    logic deg3_reg;
    logic signed [DW-1:0] a3_reg [3];
    logic signed [DW-1:0] d3_reg [3];
    logic signed [DW-1:0] p3_reg [3];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            deg3_reg <= (den2_reg == '0);
            if (den2_reg == '0 || num2_reg <= 0)
                mode3_reg <= MODE_ZERO;
            else if (num2_reg >= den2_reg)
                mode3_reg <= MODE_ONE;
            else
                mode3_reg <= MODE_DIV;
            rem3_reg <= num2_reg;
            den3_reg <= den2_reg;
            a3_reg <= a2_reg;
            d3_reg <= d2_reg;
            p3_reg <= p2_reg;
        end
    end

    // divider: one quotient bit per stage
    logic [SW:0]            drem_reg [T_FRAC_BITS+1];
    logic [SW-1:0]          dden_reg [T_FRAC_BITS+1];
    logic [T_FRAC_BITS-1:0] dq_reg   [T_FRAC_BITS+1];
    tmode_t                 dmode_reg[T_FRAC_BITS+1];
    logic                   ddeg_reg [T_FRAC_BITS+1];
    logic signed [DW-1:0]   da_reg   [T_FRAC_BITS+1][3];
    logic signed [DW-1:0]   dd_reg   [T_FRAC_BITS+1][3];
    logic signed [DW-1:0]   dp_reg   [T_FRAC_BITS+1][3];
    always_comb
    begin
        drem_reg[0]  = {1'b0, rem3_reg};
        dden_reg[0]  = den3_reg;
        dq_reg[0]    = '0;
        dmode_reg[0] = mode3_reg;
        ddeg_reg[0]  = deg3_reg;
        da_reg[0]    = a3_reg;
        dd_reg[0]    = d3_reg;
        dp_reg[0]    = p3_reg;
    end
    for (genvar i = 0; i < T_FRAC_BITS; i++)
    begin : g_div
        logic [SW:0] sh;
        assign sh = {drem_reg[i][SW-1:0], 1'b0};
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                if (sh >= {1'b0, dden_reg[i]})
                begin
                    drem_reg[i+1] <= sh - {1'b0, dden_reg[i]};
                    dq_reg[i+1]   <= {dq_reg[i][T_FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    drem_reg[i+1] <= sh;
                    dq_reg[i+1]   <= {dq_reg[i][T_FRAC_BITS-2:0], 1'b0};
                end
                dden_reg[i+1]  <= dden_reg[i];
                dmode_reg[i+1] <= dmode_reg[i];
                ddeg_reg[i+1]  <= ddeg_reg[i];
                da_reg[i+1]    <= da_reg[i];
                dd_reg[i+1]    <= dd_reg[i];
                dp_reg[i+1]    <= dp_reg[i];
            end
        end
    end

    localparam int unsigned LD = T_FRAC_BITS;
    logic [TW-1:0] t_sel;
    always_comb
    begin
        case (dmode_reg[LD])
            MODE_DIV: t_sel = {1'b0, dq_reg[LD]};
            MODE_ONE: t_sel = TW'(1) << T_FRAC_BITS;
            default:  t_sel = '0;
        endcase
    end

    // scale stage: D*t
    localparam int unsigned MW = DW + TW + 1;
    logic signed [MW-1:0] m_reg [3];
    logic signed [DW-1:0] ma_reg [3];
    logic signed [DW-1:0] mp_reg [3];
    logic mdeg_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                m_reg[k]  <= MW'(dd_reg[LD][k]) * MW'($signed({1'b0, t_sel}))
                             + (MW'(1) <<< (T_FRAC_BITS - 1));
                ma_reg[k] <= da_reg[LD][k];
                mp_reg[k] <= dp_reg[LD][k];
            end
            mdeg_reg <= ddeg_reg[LD];
        end
    end

    // near point and difference
    logic signed [DW-1:0] c_reg [3];
    logic signed [DW-1:0] g_reg [3];
    logic cdeg_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                c_reg[k] <= ma_reg[k] + DW'(m_reg[k] >>> T_FRAC_BITS);
                g_reg[k] <= mp_reg[k] - ma_reg[k] - DW'(m_reg[k] >>> T_FRAC_BITS);
            end
            cdeg_reg <= mdeg_reg;
        end
    end

    // squares
    logic [PW-1:0] sq_reg [3];
    logic signed [DW-1:0] sc_reg [3];
    logic sdeg_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= PW'(g_reg[k]) * PW'(g_reg[k]);
                sc_reg[k] <= c_reg[k];
            end
            sdeg_reg <= cdeg_reg;
        end
    end

    // sum of squares
    logic [QW-1:0] x_reg;
    logic signed [DW-1:0] xc_reg [3];
    logic xdeg_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg <= QW'(sq_reg[0]) + QW'(sq_reg[1]) + QW'(sq_reg[2]);
            xc_reg <= sc_reg;
            xdeg_reg <= sdeg_reg;
        end
    end

    // square root: one result bit per stage
    logic [63:0] rx_reg  [RN+1];
    logic [31:0] rr_reg  [RN+1];
    logic signed [DW-1:0] rc_reg [RN+1][3];
    logic rdeg_reg [RN+1];
    always_comb
    begin
        rx_reg[0]   = 64'(x_reg);
        rr_reg[0]   = '0;
        rc_reg[0]   = xc_reg;
        rdeg_reg[0] = xdeg_reg;
    end
    for (genvar i = 0; i < RN; i++)
    begin : g_sqrt
        localparam int unsigned SH = 2 * (RN - 1 - i);
        logic [65:0] trial;
        assign trial = {2'b0, rx_reg[i]} - ((66'(rr_reg[i]) << (SH + 2)) | (66'(1) << SH));
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                if (!trial[65])
                begin
                    rx_reg[i+1] <= trial[63:0];
                    rr_reg[i+1] <= {rr_reg[i][30:0], 1'b1};
                end
                else
                begin
                    rx_reg[i+1] <= rx_reg[i];
                    rr_reg[i+1] <= {rr_reg[i][30:0], 1'b0};
                end
                rc_reg[i+1]   <= rc_reg[i];
                rdeg_reg[i+1] <= rdeg_reg[i];
            end
        end
    end

    // output register
    answer_t out_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.near_x <= CW'(rc_reg[RN][0]);
            out_reg.near_y <= CW'(rc_reg[RN][1]);
            out_reg.near_z <= CW'(rc_reg[RN][2]);
            out_reg.gap <= (rr_reg[RN] > 32'(2**GAP_W - 1)) ? '1 : GAP_W'(rr_reg[RN]);
            out_reg.degenerate <= rdeg_reg[RN];
        end
    end
    assign out_ch.valid = vld_reg[NST-1];
    assign out_ch.data  = out_reg;

    logic out_stall;
    assign out_stall = out_ch.valid && !out_ch.ready;

    `PSCD_ASSERT_IMP(a_stall_hold, out_stall, !in_ch.ready, "stall leak")
    `PSCD_ASSERT_NXT(a_hold_valid, out_stall, out_ch.valid, "dropped result")
    `PSCD_ASSERT_NXT(a_hold_data, out_stall, $stable(out_ch.data), "result changed in stall")
endmodule

[verif/tb.sv]
// Testbench for point_segment_closest_distance_top: random and directed segment queries.
// Depends on pscd_pkg, pscd_if and the block; predicts the closest point and distance itself.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pscd_pkg::*;

    localparam int unsigned TF = 16;
    localparam int unsigned LATENCY = TF + 41;
    localparam int HOLD_LEN = 3 * LATENCY;
    localparam longint LIMIT = 400000;

    class closest_point_board;
        answer_t pending[$];
        int errors;
        int shown;

        function automatic longint unsigned root64(longint unsigned x);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            for (int i = 0; i < 32; i++)
            begin
                if (x >= res + bitv)
                begin
                    x -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        function automatic answer_t project(query_t q);
            longint a[3], b[3], p[3], d[3], e[3], c[3];
            longint num, den, prod, g;
            longint unsigned t, r, sq, gp;
            answer_t ans;
            a = '{q.start_x, q.start_y, q.start_z};
            b = '{q.end_x, q.end_y, q.end_z};
            p = '{q.probe_x, q.probe_y, q.probe_z};
            num = 0;
            den = 0;
            sq = 0;
            for (int k = 0; k < 3; k++)
            begin
                d[k] = b[k] - a[k];
                e[k] = p[k] - a[k];
                num += e[k] * d[k];
                den += d[k] * d[k];
            end
            ans.degenerate = (den == 0);
            if (den == 0 || num <= 0)
                t = 0;
            else if (num >= den)
                t = 64'd1 << TF;
            else
            begin
                r = num;
                t = 0;
                for (int i = 0; i < TF; i++)
                begin
                    r <<= 1;
                    t <<= 1;
                    if (r >= den)
                    begin
                        r -= den;
                        t |= 1;
                    end
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                prod = d[k] * longint'(t) + (longint'(1) << (TF - 1));
                c[k] = a[k] + (prod >>> TF);
                g = p[k] - c[k];
                if (g < 0)
                    g = -g;
                sq += longint'(g) * longint'(g);
            end
            gp = root64(sq);
            if (gp > (64'd1 << GAP_W) - 1)
                gp = (64'd1 << GAP_W) - 1;
            ans.near_x = c[0][COORD_W-1:0];
            ans.near_y = c[1][COORD_W-1:0];
            ans.near_z = c[2][COORD_W-1:0];
            ans.gap = gp[GAP_W-1:0];
            return ans;
        endfunction

        function void note_query(query_t q);
            pending.push_back(project(q));
        endfunction

        function void check_answer(answer_t got);
            answer_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("unexpected transfer %p", got);
                end
                return;
            end
            want = pending.pop_front();
            if (got.near_x !== want.near_x || got.near_y !== want.near_y ||
                got.near_z !== want.near_z || got.gap !== want.gap ||
                got.degenerate !== want.degenerate)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("mismatch: expected %p actual %p", want, got);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int send_idle;
    int recv_idle;
    logic hold_req = 1'b0;
    int hold_off = 0;
    longint cycles = 0;
    closest_point_board board;

    pscd_if #(.payload_t(query_t)) in_ch();
    pscd_if #(.payload_t(answer_t)) out_ch();

    point_segment_closest_distance_top #(.T_FRAC_BITS(TF)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_answer(out_ch.data);
        if (hold_req && hold_off < HOLD_LEN)
        begin
            hold_off <= hold_off + 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic coord_t pick_coord();
        case ($urandom_range(7))
            0: return coord_t'(24'h800000);
            1: return coord_t'(24'h7fffff);
            2: return '0;
            3: return coord_t'($urandom_range(8191)) - coord_t'(4096);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic query_t random_query();
        query_t q;
        q.start_x = pick_coord();
        q.start_y = pick_coord();
        q.start_z = pick_coord();
        q.probe_x = pick_coord();
        q.probe_y = pick_coord();
        q.probe_z = pick_coord();
        if ($urandom_range(9) == 0)
        begin
            q.end_x = q.start_x;
            q.end_y = q.start_y;
            q.end_z = q.start_z;
        end
        else
        begin
            q.end_x = pick_coord();
            q.end_y = pick_coord();
            q.end_z = pick_coord();
        end
        return q;
    endfunction

    task automatic send_query(query_t q);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= q;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        board.note_query(q);
    endtask

    function automatic query_t make_query(coord_t ax, coord_t ay, coord_t az, coord_t bx,
                                          coord_t by, coord_t bz, coord_t px, coord_t py,
                                          coord_t pz);
        query_t q;
        q = '{ax, ay, az, bx, by, bz, px, py, pz};
        return q;
    endfunction

    initial
    begin
        query_t q;
        coord_t mn;
        coord_t mx;
        board = new();
        mn = coord_t'(24'h800000);
        mx = coord_t'(24'h7fffff);
        send_idle = 29;
        recv_idle = 62;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_query(make_query(0, 0, 0, 0, 0, 0, 4096, 4096, 4096));
        send_query(make_query(mn, mn, mn, mn, mn, mn, mx, mx, mx));
        send_query(make_query(mn, mn, mn, mx, mx, mx, mx, mx, mx));
        send_query(make_query(mn, mn, mn, mx, mx, mx, mn, mn, mn));
        send_query(make_query(mn, mn, mn, mx, mx, mx, mx, mn, mx));
        send_query(make_query(mx, mn, mx, mn, mx, mn, mn, mx, mx));
        send_query(make_query(0, 0, 0, 4096, 0, 0, -4096, 4096, 0));
        send_query(make_query(0, 0, 0, 4096, 0, 0, 8192, 4096, 0));
        send_query(make_query(0, 0, 0, 4096, 0, 0, 4096, 100, 0));
        send_query(make_query(0, 0, 0, 4096, 0, 0, 2048, 100, 7));
        send_query(make_query(0, 0, 0, 3, 0, 0, 1, 5, 0));
        send_query(make_query(0, 0, 0, -3, 0, 0, -1, 5, 0));
        send_query(make_query(0, 0, 0, 1, 1, 1, 0, 0, 1));
        send_query(make_query(mx, mx, mx, mx, mx, mx, mn, mn, mn));
        send_query(make_query(mn, 0, mx, mx, 0, mn, 0, mx, 0));
        send_query(make_query(-1, -1, -1, 1, 1, 1, 0, 0, 0));

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 29 : (phase == 1) ? 62 : 0;
            recv_idle = (phase == 0) ? 62 : (phase == 1) ? 29 : 0;
            if (phase == 2)
                hold_req = 1'b1;
            for (int n = 0; n < 135; n++)
            begin
                q = random_query();
                send_query(q);
            end
        end
        in_ch.valid <= 1'b0;
        recv_idle = 10;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[point_segment_closest_distance_top.f]
+incdir+design
design/pscd_pkg.sv
design/pscd_if.sv
design/point_segment_closest_distance_top.sv
verif/tb.sv
